// ----- rtl/tgbc_pkg.sv -----
// Shared types, constants and codes of the tile grid box collision block.
// Depends on nothing; every other file but tgbc_if uses it.
package tgbc_pkg;

	// Grid limits
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLUMNS = 256;
	localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int MAP_DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

	// Tile index arithmetic: coordinates are taken to whole pixels first
	localparam int IDX_W      = 18;
	localparam int MAG_W      = IDX_W - 1;
	localparam int DIV_CNT_W  = $clog2(MAG_W);

	// Item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_HORZ = 2'd1;
	localparam logic [1:0] KIND_VERT = 2'd2;

	// Result causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_EDGE    = 2'd1;
	localparam logic [1:0] CAUSE_SOLID   = 2'd2;
	localparam logic [1:0] CAUSE_OUTSIDE = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_LEVEL_LEFT     = 3'd0;
	localparam logic [2:0] REG_LEVEL_TOP      = 3'd1;
	localparam logic [2:0] REG_LEVEL_WIDTH    = 3'd2;
	localparam logic [2:0] REG_LEVEL_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_TILE_WIDTH     = 3'd4;
	localparam logic [2:0] REG_TILE_HEIGHT    = 3'd5;
	localparam logic [2:0] REG_ROWS_IN_USE    = 3'd6;
	localparam logic [2:0] REG_COLUMNS_IN_USE = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	typedef struct packed {
		logic       in_ready;
		logic       clear_en;
		logic       capture;
		logic       div_start;
		logic [1:0] div_idx;
		logic       walk_init;
		logic       walk_next;
		logic       edge_next;
		logic       mem_rd;
		logic       cause_set;
		logic [1:0] cause_code;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic       in_valid;
		logic [1:0] in_kind;
		logic       div_done;
		logic       edge_hit;
		logic       walk_over;
		logic       edge_last;
		logic       outside;
		logic       solid;
		logic       out_free;
	} dp_status_t;

endpackage

// ----- rtl/tgbc_if.sv -----
// Valid/ready channel interfaces for check items and results.
// Depends on nothing beyond the field widths of the block.
interface tgbc_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic signed [20:0] box_left;
	logic signed [20:0] box_top;
	logic        [15:0] box_width;
	logic        [15:0] box_height;
	logic        [5:0]  cell_row;
	logic        [7:0]  cell_column;
	logic               cell_solid;

	modport source (output valid, kind, box_left, box_top, box_width, box_height,
		cell_row, cell_column, cell_solid, input ready);
	modport sink (input valid, kind, box_left, box_top, box_width, box_height,
		cell_row, cell_column, cell_solid, output ready);
endinterface

interface tgbc_rsp_if;
	logic       valid;
	logic       ready;
	logic       collides;
	logic [1:0] cause;

	modport source (output valid, collides, cause, input ready);
	modport sink (input valid, collides, cause, output ready);
endinterface

// ----- rtl/tile_grid_box_collision_core.sv -----
// Top level of the tile grid box collision block.
// Depends on tgbc_pkg, tgbc_if, tgbc_ctrl and tgbc_datapath.

// The block holds a 64 x 256 solid/open bitmap in a memory with one write port
// and one read port, and answers one item at a time with exactly one result
// transaction. After reset a clearing pass writes every cell open, one cell a
// cycle; req.ready stays low during the pass, and configuration writes are
// taken throughout. A check item runs four floor divisions (left and right
// column, top and bottom row) on one shared bit-serial divider, then an edge
// test, then, unless the edge test hits, walks the cells of both edges,
// each checked against the grid, then read. The walk stops at the first cell
// outside the grid or the first solid cell. A finished result sits in the
// output register while the next item is taken in; ready is high whenever the
// controller is idle. Write configuration only while the block is idle.
module tile_grid_box_collision_core (
	input  logic                            clk,
	input  logic                            arst_n,
	tgbc_req_if.sink                        req,
	tgbc_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [tgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tgbc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence the work of each transaction
	tgbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Hold configuration, the bitmap and the result register
	tgbc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Take a new transaction only while the controller idles
	assign req.ready = cmd.in_ready;

endmodule

// ----- rtl/tgbc_div.sv -----
// Iterative floor divider of a signed pixel coordinate by an unsigned tile size.
// One quotient bit per cycle. Depends on tgbc_pkg.
module tgbc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [tgbc_pkg::IDX_W-1:0] dividend,
	input  logic        [7:0]             divisor,
	output logic                          done,
	output logic signed [tgbc_pkg::IDX_W-1:0] quot
);
	import tgbc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]     u_q;
	logic [7:0]           rem_q;
	logic [7:0]           d_q;
	logic [8:0]           sh;
	logic                 ge;

	assign sh = {rem_q, u_q[MAG_W-1]};
	assign ge = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// floor(a/b) for negative a is ~(~a / b)
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[IDX_W-1];
			u_q   <= dividend[IDX_W-1] ? ~dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 8'(sh - {1'b0, d_q}) : sh[7:0];
			u_q   <= {u_q[MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? ~{1'b0, u_q} : {1'b0, u_q};

endmodule

// ----- rtl/tgbc_datapath.sv -----
// Datapath: configuration registers, item capture, tile index slots, walk
// counter, grid bitmap memory and result register. Depends on tgbc_pkg,
// tgbc_if and tgbc_div.
module tgbc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgbc_pkg::dp_cmd_t             cmd,
	output tgbc_pkg::dp_status_t          status,
	tgbc_req_if.sink                      req,
	tgbc_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [tgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tgbc_pkg::*;

	// Configuration
	logic signed [20:0] lvl_left_q, lvl_top_q;
	logic [19:0] lvl_w_q, lvl_h_q;
	logic [7:0]  tile_w_q, tile_h_q;
	logic [6:0]  rows_q;
	logic [8:0]  cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_left_q <= '0;
			lvl_top_q  <= '0;
			lvl_w_q    <= '0;
			lvl_h_q    <= '0;
			tile_w_q   <= 8'd16;
			tile_h_q   <= 8'd16;
			rows_q     <= 7'd64;
			cols_q     <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_LEFT:     lvl_left_q <= cfg_wdata[20:0];
				REG_LEVEL_TOP:      lvl_top_q  <= cfg_wdata[20:0];
				REG_LEVEL_WIDTH:    lvl_w_q    <= cfg_wdata[19:0];
				REG_LEVEL_HEIGHT:   lvl_h_q    <= cfg_wdata[19:0];
				REG_TILE_WIDTH:     tile_w_q   <= cfg_wdata[7:0];
				REG_TILE_HEIGHT:    tile_h_q   <= cfg_wdata[7:0];
				REG_ROWS_IN_USE:    rows_q     <= cfg_wdata[6:0];
				REG_COLUMNS_IN_USE: cols_q     <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Captured item
	logic [1:0]         kind_q;
	logic signed [20:0] box_left_q, box_top_q;
	logic [15:0]        box_w_q, box_h_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= req.kind;
			box_left_q <= req.box_left;
			box_top_q  <= req.box_top;
			box_w_q    <= req.box_width;
			box_h_q    <= req.box_height;
		end
	end

	logic               horz;
	logic signed [21:0] left_x, top_x, right_x, bottom_x, right_m1, bottom_m1;
	logic signed [22:0] lvl_l, lvl_t, lvl_r, lvl_b;

	assign horz      = (kind_q == KIND_HORZ);
	assign left_x    = 22'(box_left_q);
	assign top_x     = 22'(box_top_q);
	assign right_x   = left_x + 22'(box_w_q);
	assign bottom_x  = top_x + 22'(box_h_q);
	assign right_m1  = right_x - 22'sd1;
	assign bottom_m1 = bottom_x - 22'sd1;
	assign lvl_l     = 23'(lvl_left_q);
	assign lvl_t     = 23'(lvl_top_q);
	assign lvl_r     = lvl_l + 23'(lvl_w_q);
	assign lvl_b     = lvl_t + 23'(lvl_h_q);

	// Divider feed: whole-pixel coordinate over tile size in pixels
	logic signed [IDX_W-1:0] div_a, div_q;
	logic [7:0]              div_b, tile_w_eff, tile_h_eff;
	logic                    div_done;

	assign tile_w_eff = (tile_w_q == 8'd0) ? 8'd1 : tile_w_q;
	assign tile_h_eff = (tile_h_q == 8'd0) ? 8'd1 : tile_h_q;

	always_comb begin
		case (cmd.div_idx)
			2'd0:    div_a = left_x[21:4];
			2'd1:    div_a = top_x[21:4];
			2'd2:    div_a = right_m1[21:4];
			default: div_a = bottom_m1[21:4];
		endcase
		div_b = cmd.div_idx[0] ? tile_h_eff : tile_w_eff;
	end

	tgbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_q)
	);

	logic signed [IDX_W-1:0] c0_q, r0_q, c1_q, r1_q;

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_idx)
				2'd0:    c0_q <= div_q;
				2'd1:    r0_q <= div_q;
				2'd2:    c1_q <= div_q;
				default: r1_q <= div_q;
			endcase
		end
	end

	// Walk along one edge, then the other
	logic signed [IDX_W-1:0] i_q, walk_start, walk_stop, cell_r, cell_c;
	logic                    edge_q;

	assign walk_start = horz ? r0_q : c0_q;
	assign walk_stop  = horz ? r1_q : c1_q;
	assign cell_r     = horz ? i_q : (edge_q ? r1_q : r0_q);
	assign cell_c     = horz ? (edge_q ? c1_q : c0_q) : i_q;

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			i_q    <= walk_start;
			edge_q <= 1'b0;
		end else if (cmd.edge_next) begin
			i_q    <= walk_start;
			edge_q <= 1'b1;
		end else if (cmd.walk_next) begin
			i_q <= i_q + 1'b1;
		end
	end

	logic outside;
	assign outside = (cell_r < 0) || (cell_r >= $signed({12'b0, rows_q})) ||
		(cell_r >= MAX_ROWS) || (cell_c < 0) ||
		(cell_c >= $signed({10'b0, cols_q})) || (cell_c >= MAX_COLUMNS);

	// Grid bitmap
	logic              mem [MAP_DEPTH];
	logic [ADDR_W-1:0] clr_q, rd_addr, ld_addr, wr_addr;
	logic              ld_we, wr_en, wr_data, rd_q;

	assign rd_addr = ADDR_W'(cell_r[ROW_W-1:0] * MAX_COLUMNS + cell_c[COL_W-1:0]);
	assign ld_addr = ADDR_W'(req.cell_row * MAX_COLUMNS + req.cell_column);
	assign ld_we   = cmd.capture && (req.kind == KIND_LOAD) &&
		(req.cell_row < MAX_ROWS) && (req.cell_column < MAX_COLUMNS);
	assign wr_en   = cmd.clear_en || ld_we;
	assign wr_addr = cmd.clear_en ? clr_q : ld_addr;
	assign wr_data = cmd.clear_en ? 1'b0 : req.cell_solid;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.mem_rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear_en)
			clr_q <= clr_q + 1'b1;
	end

	// Cause and result register
	logic [1:0] cause_q;
	logic       rsp_valid_q, rsp_coll_q;
	logic [1:0] rsp_cause_q;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			cause_q <= CAUSE_NONE;
		else if (cmd.cause_set)
			cause_q <= cmd.cause_code;
		if (cmd.out_load) begin
			rsp_coll_q  <= (cause_q != CAUSE_NONE);
			rsp_cause_q <= cause_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.out_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.collides = rsp_coll_q;
	assign rsp.cause    = rsp_cause_q;

	assign status.clear_done = (clr_q == ADDR_W'(MAP_DEPTH - 1));
	assign status.in_valid   = req.valid;
	assign status.in_kind    = req.kind;
	assign status.div_done   = div_done;
	assign status.edge_hit   = horz ? ((left_x < lvl_l) || (right_x > lvl_r))
		: ((top_x < lvl_t) || (bottom_x > lvl_b));
	assign status.walk_over  = (i_q > walk_stop);
	assign status.edge_last  = edge_q;
	assign status.outside    = outside;
	assign status.solid      = rd_q;
	assign status.out_free   = !rsp_valid_q || rsp.ready;

endmodule

// ----- rtl/tgbc_ctrl.sv -----
// Controller state machine: clearing pass, item intake, division sequence,
// edge test, edge walk and result hand-off. Depends on tgbc_pkg.
module tgbc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tgbc_pkg::dp_status_t status,
	output tgbc_pkg::dp_cmd_t    cmd
);
	import tgbc_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_DIV_GO   = 8'b0000_0100,
		S_DIV_WAIT = 8'b0000_1000,
		S_EDGE     = 8'b0001_0000,
		S_WALK     = 8'b0010_0000,
		S_READ     = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q;

	always_comb begin
		cmd         = '0;
		cmd.div_idx = idx_q;
		state_d     = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) begin
					cmd.capture = 1'b1;
					if (status.in_kind == KIND_HORZ || status.in_kind == KIND_VERT)
						state_d = S_DIV_GO;
					else
						state_d = S_DONE;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done)
					state_d = (idx_q == 2'd3) ? S_EDGE : S_DIV_GO;
			end
			S_EDGE: begin
				if (status.edge_hit) begin
					cmd.cause_set  = 1'b1;
					cmd.cause_code = CAUSE_EDGE;
					state_d = S_DONE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (status.walk_over) begin
					if (status.edge_last)
						state_d = S_DONE;
					else
						cmd.edge_next = 1'b1;
				end else if (status.outside) begin
					cmd.cause_set  = 1'b1;
					cmd.cause_code = CAUSE_OUTSIDE;
					state_d = S_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (status.solid) begin
					cmd.cause_set  = 1'b1;
					cmd.cause_code = CAUSE_SOLID;
					state_d = S_DONE;
				end else begin
					cmd.walk_next = 1'b1;
					state_d = S_WALK;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				idx_q <= 2'd0;
			else if (state_q == S_DIV_WAIT && status.div_done)
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ----- rtl/tgbc_checker.sv -----
// Port-level checks of the tile grid box collision block, with its bind.
// Depends on the top level's ports and the cause codes of tgbc_pkg.
module tgbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_collides,
	input logic [1:0] rsp_cause
);

	// A stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_cause) && $stable(rsp_collides))
		else $error("result changed while stalled");

	// The collision flag follows the cause
	a_coll_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_collides == (rsp_cause != tgbc_pkg::CAUSE_NONE)))
		else $error("collides disagrees with cause");

	// One item at a time: intake closes after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

endmodule

bind tile_grid_box_collision_core tgbc_checker u_tgbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_collides (rsp.collides),
	.rsp_cause    (rsp.cause)
);
